>>> src/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES package
// Types, S-box and round helper functions shared by the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int RoundCount = 10;
    localparam int KeyCount   = RoundCount + 1;
    localparam int KeyIdxW    = $clog2(KeyCount);

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [63:0] plaintext_high;
        logic [63:0] plaintext_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] ciphertext_high;
        logic [63:0] ciphertext_low;
    } aes_out_t;

    typedef logic [127:0] aes_block_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte k sits at bits [127-8k -: 8]; byte r + 4c is row r, column c.
    function automatic aes_block_t sub_shift(input aes_block_t s);
        aes_block_t o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
            end
        end
        return o;
    endfunction

    function automatic aes_block_t mix_columns(input aes_block_t s);
        aes_block_t o;
        logic [7:0] a0, a1, a2, a3, al;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            o[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            o[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            o[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            o[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

    function automatic aes_block_t next_round_key(input aes_block_t k, input logic [7:0] rc);
        aes_block_t o;
        logic [31:0] t;
        t = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        o[127:96] = k[127:96] ^ t;
        o[95:64]  = k[95:64] ^ o[127:96];
        o[63:32]  = k[63:32] ^ o[95:64];
        o[31:0]   = k[31:0] ^ o[63:32];
        return o;
    endfunction

endpackage
`default_nettype wire

>>> src/aes128_block_encrypt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Fully pipelined AES-128 cipher with an APB key port.
// ----------------------------------------------------------------------------
// Use: write key_high (0x0) and key_low (0x8) over APB; each write restarts
// key expansion, during which busy is high.
// Issue a request by raising start with the plaintext while busy is low.
// One request may enter each cycle while busy is low. The ciphertext appears
// on result, marked by done for one cycle: the initial key add registers at
// the accepting edge, then one stage per round, ten round stages.
// After reset the key is all zeros and busy stays high while that key
// expands. The receiver cannot stall; results are never held back.
// Write the key only when no request is in flight.
// ----------------------------------------------------------------------------
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  aes_in_t          request,
    output logic             done,
    output aes_out_t         result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    logic        key_wr, expanding;
    logic [63:0] key_high, key_low;
    aes_block_t  round_keys [KeyCount];
    logic        v_reg;
    aes_block_t  s_reg;
    logic        vld [KeyCount];
    aes_block_t  st  [KeyCount];

    assign pready = 1'b1;
    assign key_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3])
            REG_KEY_HIGH: prdata = key_high;
            REG_KEY_LOW:  prdata = key_low;
        endcase
    end

    aes_key_sched u_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_wr     (key_wr),
        .key_sel    (paddr[3]),
        .key_data   (pwdata),
        .key_high   (key_high),
        .key_low    (key_low),
        .round_keys (round_keys),
        .expanding  (expanding)
    );

    assign busy = expanding;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s_reg <= {request.plaintext_high, request.plaintext_low} ^ round_keys[0];
    end

    assign vld[0] = v_reg;
    assign st[0]  = s_reg;

    for (genvar g = 1; g < KeyCount; g++)
    begin : g_round
        aes_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .last      (g == KeyCount - 1),
            .in_valid  (vld[g - 1]),
            .in_state  (st[g - 1]),
            .round_key (round_keys[g]),
            .out_valid (vld[g]),
            .out_state (st[g])
        );
    end

    assign done   = vld[KeyCount - 1];
    assign result = {st[KeyCount - 1][127:64], st[KeyCount - 1][63:0]};

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_wr |=> busy) else $error("key write did not restart expansion");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld[KeyCount - 2])) else $error("done without prior stage");
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> v_reg) else $error("accepted request lost");

endmodule
`default_nettype wire

>>> src/aes_key_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES key schedule
// Holds the key registers and expands the round keys, one per cycle.
// ----------------------------------------------------------------------------
module aes_key_sched
    import aes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        key_wr,
    input  wire logic        key_sel,
    input  wire logic [63:0] key_data,
    output logic      [63:0] key_high,
    output logic      [63:0] key_low,
    output aes_block_t       round_keys [KeyCount],
    output logic             expanding
);

    logic [63:0]        key_high_reg, key_low_reg;
    logic [KeyIdxW-1:0] idx_reg;
    logic [7:0]         rc_reg;
    logic               busy_reg;
    aes_block_t         rk_reg [KeyCount];
    aes_block_t         prev_key;

    assign prev_key = (idx_reg == KeyIdxW'(1)) ? {key_high_reg, key_low_reg}
                                               : rk_reg[idx_reg - KeyIdxW'(1)];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            busy_reg     <= 1'b1;
            idx_reg      <= KeyIdxW'(1);
            rc_reg       <= 8'h01;
        end
        else if (key_wr)
        begin
            if (key_sel)
                key_low_reg <= key_data;
            else
                key_high_reg <= key_data;
            busy_reg <= 1'b1;
            idx_reg  <= KeyIdxW'(1);
            rc_reg   <= 8'h01;
        end
        else if (busy_reg)
        begin
            idx_reg <= idx_reg + KeyIdxW'(1);
            rc_reg  <= xtime(rc_reg);
            if (idx_reg == KeyIdxW'(KeyCount - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg[0] <= {key_high_reg, key_low_reg};
        if (busy_reg && !key_wr)
            rk_reg[idx_reg] <= next_round_key(prev_key, rc_reg);
    end

    assign key_high    = key_high_reg;
    assign key_low     = key_low_reg;
    assign round_keys  = rk_reg;
    assign expanding   = busy_reg;

endmodule
`default_nettype wire

>>> src/aes_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round; the final round skips MixColumns.
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       last,
    input  wire logic       in_valid,
    input  aes_block_t      in_state,
    input  aes_block_t      round_key,
    output logic            out_valid,
    output aes_block_t      out_state
);

    logic       valid_reg;
    aes_block_t state_reg, shifted;

    assign shifted = sub_shift(in_state);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= (last ? shifted : mix_columns(shifted)) ^ round_key;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Drives plaintext requests under varying sender gaps, programs several keys
// over APB between phases, and checks each ciphertext against an in-bench
// AES-128 cipher with its own key schedule.
// ----------------------------------------------------------------------------
module testbench;
    import aes_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 20;
    localparam logic [3:0] AddrKeyHigh = 4'(REG_KEY_HIGH) << 3;
    localparam logic [3:0] AddrKeyLow  = 4'(REG_KEY_LOW) << 3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    aes_in_t     request;
    logic        done;
    aes_out_t    result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    aes_in_t     plaintext_q[$];
    aes_out_t    ciphertext_q[$];
    logic [63:0] key_hi_m;
    logic [63:0] key_lo_m;
    logic [127:0] round_keys[11];
    int          gap_pct;
    int          errors;
    int          cycles;

    logic [7:0] sbox_tbl [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    aes128_block_encrypt dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    function automatic logic [7:0] gf_mul2(input logic [7:0] x);
        logic [7:0] y;
        y = {x[6:0], 1'b0};
        if (x[7])
        begin
            y = y ^ 8'h1b;
        end
        return y;
    endfunction

    function automatic void expand_schedule();
        logic [31:0] w[44];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        w[0] = key_hi_m[63:32];
        w[1] = key_hi_m[31:0];
        w[2] = key_lo_m[63:32];
        w[3] = key_lo_m[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i - 1];
            if (i % 4 == 0)
            begin
                t = {sbox_tbl[t[23:16]] ^ rcon, sbox_tbl[t[15:8]],
                     sbox_tbl[t[7:0]], sbox_tbl[t[31:24]]};
                rcon = gf_mul2(rcon);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int r = 0; r < 11; r++)
        begin
            round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        end
    endfunction

    function automatic aes_out_t encrypt_block(input aes_in_t pt);
        logic [127:0] blk;
        logic [7:0]   s[16];
        logic [7:0]   t[16];
        logic [7:0]   a0, a1, a2, a3;
        aes_out_t     ct;
        blk = {pt.plaintext_high, pt.plaintext_low} ^ round_keys[0];
        for (int k = 0; k < 16; k++)
        begin
            s[k] = blk[127 - 8 * k -: 8];
        end
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    t[r + 4 * c] = sbox_tbl[s[r + 4 * ((c + r) % 4)]];
                end
            end
            if (rnd < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4 * c];
                    a1 = t[4 * c + 1];
                    a2 = t[4 * c + 2];
                    a3 = t[4 * c + 3];
                    t[4 * c]     = gf_mul2(a0) ^ gf_mul2(a1) ^ a1 ^ a2 ^ a3;
                    t[4 * c + 1] = a0 ^ gf_mul2(a1) ^ gf_mul2(a2) ^ a2 ^ a3;
                    t[4 * c + 2] = a0 ^ a1 ^ gf_mul2(a2) ^ gf_mul2(a3) ^ a3;
                    t[4 * c + 3] = gf_mul2(a0) ^ a0 ^ a1 ^ a2 ^ gf_mul2(a3);
                end
            end
            for (int k = 0; k < 16; k++)
            begin
                s[k] = t[k] ^ round_keys[rnd][127 - 8 * k -: 8];
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            blk[127 - 8 * k -: 8] = s[k];
        end
        ct.ciphertext_high = blk[127:64];
        ct.ciphertext_low  = blk[63:0];
        return ct;
    endfunction

    function automatic aes_in_t random_block();
        aes_in_t b;
        b.plaintext_high = {$urandom, $urandom};
        b.plaintext_low  = {$urandom, $urandom};
        return b;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Driver: present queued requests, hold while busy, idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                ciphertext_q.push_back(encrypt_block(request));
                void'(plaintext_q.pop_front());
            end
            if (start && busy)
            begin
                start <= 1'b1;
            end
            else if (plaintext_q.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                start   <= 1'b1;
                request <= plaintext_q[0];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each ciphertext with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (ciphertext_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors = errors + 1;
            end
            else
            begin
                if (result.ciphertext_high !== ciphertext_q[0].ciphertext_high)
                begin
                    $display("%0t: ciphertext_high expected %h actual %h", $time,
                             ciphertext_q[0].ciphertext_high, result.ciphertext_high);
                    errors = errors + 1;
                end
                if (result.ciphertext_low !== ciphertext_q[0].ciphertext_low)
                begin
                    $display("%0t: ciphertext_low expected %h actual %h", $time,
                             ciphertext_q[0].ciphertext_low, result.ciphertext_low);
                    errors = errors + 1;
                end
                void'(ciphertext_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (plaintext_q.size() != 0 || ciphertext_q.size() != 0 || start)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == AddrKeyHigh)
        begin
            key_hi_m = value;
        end
        else if (addr == AddrKeyLow)
        begin
            key_lo_m = value;
        end
        expand_schedule();
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            plaintext_q.push_back(random_block());
        end
    endtask

    initial
    begin
        errors   = 0;
        cycles   = 0;
        gap_pct  = 0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        key_hi_m = '0;
        key_lo_m = '0;
        expand_schedule();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key: extremes, alternating bits and the end bits.
        plaintext_q.push_back('0);
        plaintext_q.push_back('1);
        plaintext_q.push_back({64'h0011223344556677, 64'h8899aabbccddeeff});
        plaintext_q.push_back({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
        plaintext_q.push_back({64'h8000000000000000, 64'h0000000000000001});
        wait_drained();

        write_key(AddrKeyHigh, 64'h0001020304050607);
        write_key(AddrKeyLow, 64'h08090a0b0c0d0e0f);
        plaintext_q.push_back({64'h0011223344556677, 64'h8899aabbccddeeff});
        plaintext_q.push_back('0);
        plaintext_q.push_back('1);

        write_key(AddrKeyHigh, '1);
        write_key(AddrKeyLow, '1);
        plaintext_q.push_back('0);
        plaintext_q.push_back('1);

        // Change one half only.
        write_key(AddrKeyLow, '0);
        plaintext_q.push_back('1);
        plaintext_q.push_back('0);
        plaintext_q.push_back({64'h0123456789abcdef, 64'hfedcba9876543210});

        gap_pct = 21;
        write_key(AddrKeyHigh, {$urandom, $urandom});
        write_key(AddrKeyLow, {$urandom, $urandom});
        queue_random(180);

        gap_pct = 57;
        write_key(AddrKeyHigh, {$urandom, $urandom});
        queue_random(180);

        gap_pct = 0;
        write_key(AddrKeyLow, {$urandom, $urandom});
        queue_random(100);
        write_key(AddrKeyHigh, '0);
        write_key(AddrKeyLow, '0);
        queue_random(90);

        wait_drained();
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/aes_pkg.sv
src/aes_key_sched.sv
src/aes_round.sv
src/aes128_block_encrypt.sv
verif/testbench.sv
